// ----- src/assert_macros.svh -----
// Assertion helpers for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define SOS_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define SOS_NEVER(lbl, clk, rstn, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);
`else
`define SOS_ASSERT(lbl, clk, rstn, prop, msg)
`define SOS_NEVER(lbl, clk, rstn, cond, msg)
`endif

`endif

// ----- src/sos_pkg.sv -----
`default_nettype none

package sos_pkg;

    localparam int DATA_W    = 32;
    localparam int DIM_W     = 4;
    localparam int CFG_IDX_W = 1;

    localparam logic [DIM_W-1:0] DIM_RESET = 4'd8;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ROW_COUNT = 1'b0,
        CFG_COL_COUNT = 1'b1
    } cfg_idx_t;

    typedef struct packed {
        logic [DIM_W-1:0] rows;
        logic [DIM_W-1:0] cols;
    } cmd_t;

    typedef enum logic [1:0] {
        DIR_RIGHT = 2'd0,
        DIR_DOWN  = 2'd1,
        DIR_LEFT  = 2'd2,
        DIR_UP    = 2'd3
    } dir_t;

    typedef enum logic {
        BK_IDLE = 1'b0,
        BK_WALK = 1'b1
    } back_state_t;

    function automatic logic [DIM_W-1:0] clamp_dim(
        input logic [DIM_W-1:0] v,
        input logic [DIM_W-1:0] maxv
    );
        logic [DIM_W-1:0] res;
        if (v == '0)
            res = DIM_W'(1);
        else if (v > maxv)
            res = maxv;
        else
            res = v;
        return res;
    endfunction

endpackage

`default_nettype wire

// ----- src/sos_store.sv -----
`default_nettype none

module sos_store
#(
    parameter int DEPTH  = 64,
    parameter int ADDR_W = 6,
    parameter int DATA_W = 32
)
(
    input  wire logic              clk,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [DATA_W-1:0] wr_data,
    input  wire logic              rd_en,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic      [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] store_mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            store_mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= store_mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ----- src/sos_front.sv -----
`default_nettype none

module sos_front
    import sos_pkg::*;
#(
    parameter int MAX_ROWS = 8,
    parameter int MAX_COLS = 8,
    parameter int ADDR_W   = 6
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [DIM_W-1:0]     cfg_data,
    input  wire logic                 in_valid,
    input  wire logic                 hold,
    input  wire logic [DATA_W-1:0]    element,
    output logic                      in_stall,
    output logic                      wr_en,
    output logic      [ADDR_W-1:0]    wr_addr,
    output logic      [DATA_W-1:0]    wr_data,
    output logic                      cmd_push,
    output cmd_t                      cmd
);

    localparam int TOT_W = 2 * DIM_W;

    logic [DIM_W-1:0]  rows_reg, rows_next;
    logic [DIM_W-1:0]  cols_reg, cols_next;
    logic [ADDR_W-1:0] loaded_reg, loaded_next;
    logic [DIM_W-1:0]  rows_eff, cols_eff;
    logic [TOT_W-1:0]  total;
    logic [ADDR_W:0]   loaded_inc;
    logic              accept;
    logic              done;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_reg   <= DIM_RESET;
            cols_reg   <= DIM_RESET;
            loaded_reg <= '0;
        end
        else
        begin
            rows_reg   <= rows_next;
            cols_reg   <= cols_next;
            loaded_reg <= loaded_next;
        end
    end

    always_comb
    begin
        rows_next = rows_reg;
        cols_next = cols_reg;
        if (cfg_we)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_ROW_COUNT: rows_next = cfg_data;
                CFG_COL_COUNT: cols_next = cfg_data;
                default:       ;
            endcase
        end
    end

    assign rows_eff   = clamp_dim(rows_reg, DIM_W'(MAX_ROWS));
    assign cols_eff   = clamp_dim(cols_reg, DIM_W'(MAX_COLS));
    assign total      = TOT_W'(rows_eff) * TOT_W'(cols_eff);
    assign loaded_inc = {1'b0, loaded_reg} + (ADDR_W+1)'(1);
    assign done       = TOT_W'(loaded_inc) >= total;

    assign in_stall = hold;
    assign accept   = in_valid && !hold;

    always_comb
    begin
        loaded_next = loaded_reg;
        if (accept)
        begin
            loaded_next = done ? '0 : loaded_inc[ADDR_W-1:0];
        end
    end

    assign wr_en     = accept;
    assign wr_addr   = loaded_reg;
    assign wr_data   = element;
    assign cmd_push  = accept && done;
    assign cmd.rows  = rows_eff;
    assign cmd.cols  = cols_eff;

endmodule

`default_nettype wire

// ----- src/sos_cmd_queue.sv -----
`default_nettype none

module sos_cmd_queue
    import sos_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    input  cmd_t      push_cmd,
    input  wire logic pop,
    output cmd_t      head,
    output logic [1:0] count
);

    cmd_t       entry_reg [2];
    logic       wptr_reg, wptr_next;
    logic       rptr_reg, rptr_next;
    logic [1:0] count_reg, count_next;
    logic       do_push;
    logic       do_pop;

    assign do_push = push && (count_reg != 2'd2);
    assign do_pop  = pop && (count_reg != 2'd0);

    always_comb
    begin
        wptr_next  = do_push ? !wptr_reg : wptr_reg;
        rptr_next  = do_pop ? !rptr_reg : rptr_reg;
        count_next = count_reg + {1'b0, do_push} - {1'b0, do_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= 1'b0;
            rptr_reg  <= 1'b0;
            count_reg <= 2'd0;
        end
        else
        begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wptr_reg] <= push_cmd;
        end
    end

    assign head  = entry_reg[rptr_reg];
    assign count = count_reg;

endmodule

`default_nettype wire

// ----- src/sos_back.sv -----
`default_nettype none

module sos_back
    import sos_pkg::*;
#(
    parameter int MAX_ROWS = 8,
    parameter int MAX_COLS = 8,
    parameter int ADDR_W   = 6
)
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                cmd_valid,
    input  cmd_t                     cmd,
    output logic                     cmd_pop,
    output logic                     rd_en,
    output logic      [ADDR_W-1:0]   rd_addr,
    input  wire logic [DATA_W-1:0]   rd_data,
    output logic                     out_valid,
    input  wire logic                out_stall,
    output logic      [DATA_W-1:0]   value,
    output logic                     final_res
);

    localparam int RW    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int CW    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int PW    = RW + DIM_W + 1;
    localparam int TOT_W = 2 * DIM_W;

    back_state_t       state_reg, state_next;
    dir_t              dir_reg, dir_next;
    logic [RW-1:0]     r_reg, r_next;
    logic [CW-1:0]     c_reg, c_next;
    logic [RW-1:0]     top_reg, top_next;
    logic [RW-1:0]     bot_reg, bot_next;
    logic [CW-1:0]     left_reg, left_next;
    logic [CW-1:0]     right_reg, right_next;
    logic [DIM_W-1:0]  cols_reg, cols_next;
    logic [ADDR_W-1:0] issued_reg, issued_next;
    logic [ADDR_W-1:0] last_reg, last_next;
    logic              inflight_reg;
    logic              inflight_final_reg;

    logic [DATA_W-1:0] ofifo_value_reg [2];
    logic              ofifo_final_reg [2];
    logic              owptr_reg;
    logic              orptr_reg;
    logic [1:0]        ocount_reg;

    logic [TOT_W-1:0]  total;
    logic [PW-1:0]     walk_addr;
    logic              out_pop;
    logic              credit;
    logic              issue;
    logic              is_last;

    assign total     = TOT_W'(cmd.rows) * TOT_W'(cmd.cols);
    assign walk_addr = PW'(r_reg) * PW'(cols_reg) + PW'(c_reg);
    assign rd_addr   = walk_addr[ADDR_W-1:0];
    assign is_last   = issued_reg == last_reg;
    assign out_pop   = out_valid && !out_stall;
    assign credit    = ((ocount_reg + {1'b0, inflight_reg}) < 2'd2) || out_pop;
    assign rd_en     = issue;

    always_comb
    begin
        state_next  = state_reg;
        dir_next    = dir_reg;
        r_next      = r_reg;
        c_next      = c_reg;
        top_next    = top_reg;
        bot_next    = bot_reg;
        left_next   = left_reg;
        right_next  = right_reg;
        cols_next   = cols_reg;
        issued_next = issued_reg;
        last_next   = last_reg;
        cmd_pop     = 1'b0;
        issue       = 1'b0;
        case (state_reg)
            BK_IDLE:
            begin
                if (cmd_valid)
                begin
                    state_next  = BK_WALK;
                    dir_next    = DIR_RIGHT;
                    r_next      = '0;
                    c_next      = '0;
                    top_next    = '0;
                    left_next   = '0;
                    bot_next    = RW'(cmd.rows - DIM_W'(1));
                    right_next  = CW'(cmd.cols - DIM_W'(1));
                    cols_next   = cmd.cols;
                    issued_next = '0;
                    last_next   = ADDR_W'(total - TOT_W'(1));
                end
            end
            BK_WALK:
            begin
                if (credit)
                begin
                    issue = 1'b1;
                    if (is_last)
                    begin
                        state_next = BK_IDLE;
                        cmd_pop    = 1'b1;
                    end
                    else
                    begin
                        issued_next = issued_reg + ADDR_W'(1);
                        case (dir_reg)
                            DIR_RIGHT:
                            begin
                                if (c_reg < right_reg)
                                    c_next = c_reg + CW'(1);
                                else
                                begin
                                    top_next = top_reg + RW'(1);
                                    dir_next = DIR_DOWN;
                                    r_next   = r_reg + RW'(1);
                                end
                            end
                            DIR_DOWN:
                            begin
                                if (r_reg < bot_reg)
                                    r_next = r_reg + RW'(1);
                                else
                                begin
                                    right_next = right_reg - CW'(1);
                                    dir_next   = DIR_LEFT;
                                    c_next     = c_reg - CW'(1);
                                end
                            end
                            DIR_LEFT:
                            begin
                                if (c_reg > left_reg)
                                    c_next = c_reg - CW'(1);
                                else
                                begin
                                    bot_next = bot_reg - RW'(1);
                                    dir_next = DIR_UP;
                                    r_next   = r_reg - RW'(1);
                                end
                            end
                            DIR_UP:
                            begin
                                if (r_reg > top_reg)
                                    r_next = r_reg - RW'(1);
                                else
                                begin
                                    left_next = left_reg + CW'(1);
                                    dir_next  = DIR_RIGHT;
                                    c_next    = c_reg + CW'(1);
                                end
                            end
                            default: dir_next = DIR_RIGHT;
                        endcase
                    end
                end
            end
            default: state_next = BK_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= BK_IDLE;
            inflight_reg <= 1'b0;
            owptr_reg    <= 1'b0;
            orptr_reg    <= 1'b0;
            ocount_reg   <= 2'd0;
        end
        else
        begin
            state_reg    <= state_next;
            inflight_reg <= issue;
            if (inflight_reg)
                owptr_reg <= !owptr_reg;
            if (out_pop)
                orptr_reg <= !orptr_reg;
            ocount_reg <= ocount_reg + {1'b0, inflight_reg} - {1'b0, out_pop};
        end
    end

    always_ff @(posedge clk)
    begin
        dir_reg            <= dir_next;
        r_reg              <= r_next;
        c_reg              <= c_next;
        top_reg            <= top_next;
        bot_reg            <= bot_next;
        left_reg           <= left_next;
        right_reg          <= right_next;
        cols_reg           <= cols_next;
        issued_reg         <= issued_next;
        last_reg           <= last_next;
        inflight_final_reg <= is_last;
        if (inflight_reg)
        begin
            ofifo_value_reg[owptr_reg] <= rd_data;
            ofifo_final_reg[owptr_reg] <= inflight_final_reg;
        end
    end

    assign out_valid = ocount_reg != 2'd0;
    assign value     = ofifo_value_reg[orptr_reg];
    assign final_res = ofifo_final_reg[orptr_reg];

endmodule

`default_nettype wire

// ----- src/spiral_order_scan_core.sv -----
// Spiral order scan.
// Input channel (in_valid / in_stall / element): one matrix element per beat,
// row-major. Matrix size comes from row_count (index 0) and col_count
// (index 1) on the cfg write port; 0 reads as 1, values above the maximum
// read as the maximum. Both reset to 8.
// Output channel (out_valid / out_stall / value / final_res): every element
// in clockwise spiral order from the top-left cell, final_res set on the
// last beat of each matrix.
// Loading takes an element each beat while in_stall is low; the last one
// queues a command for the spiral walker, whose reads are registered in the
// store and then written into the output buffer. Results leave one per
// cycle while out_stall is low. in_stall is held high after the last
// element of a matrix is accepted until the final read of its spiral is
// issued, so loader and walker never both use the single store they share.
// A stalled receiver only pauses the walker; results are held in a
// two-beat output buffer and none are dropped.
// Reset clears the load count, the command queue and the output buffer.
`default_nettype none

`include "assert_macros.svh"

module spiral_order_scan_core
    import sos_pkg::*;
#(
    parameter int MAX_ROWS = 8,
    parameter int MAX_COLS = 8
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [DIM_W-1:0]     cfg_data,
    input  wire logic                 in_valid,
    output logic                      in_stall,
    input  wire logic signed [DATA_W-1:0] element,
    output logic                      out_valid,
    input  wire logic                 out_stall,
    output logic signed [DATA_W-1:0]  value,
    output logic                      final_res
);

    localparam int CELLS  = MAX_ROWS * MAX_COLS;
    localparam int ADDR_W = (CELLS > 1) ? $clog2(CELLS) : 1;

    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [DATA_W-1:0] wr_data;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic [DATA_W-1:0] rd_data;
    logic              cmd_push;
    logic              cmd_pop;
    cmd_t              cmd_in;
    cmd_t              cmd_head;
    logic [1:0]        cmd_count;
    logic [DATA_W-1:0] value_raw;

    sos_front #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_COLS (MAX_COLS),
        .ADDR_W   (ADDR_W)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .hold      (cmd_count != 2'd0),
        .element   (element),
        .in_stall  (in_stall),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .cmd_push  (cmd_push),
        .cmd       (cmd_in)
    );

    sos_cmd_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (cmd_push),
        .push_cmd (cmd_in),
        .pop      (cmd_pop),
        .head     (cmd_head),
        .count    (cmd_count)
    );

    sos_store #(
        .DEPTH  (CELLS),
        .ADDR_W (ADDR_W),
        .DATA_W (DATA_W)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    sos_back #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_COLS (MAX_COLS),
        .ADDR_W   (ADDR_W)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_count != 2'd0),
        .cmd       (cmd_head),
        .cmd_pop   (cmd_pop),
        .rd_en     (rd_en),
        .rd_addr   (rd_addr),
        .rd_data   (rd_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .value     (value_raw),
        .final_res (final_res)
    );

    assign value = $signed(value_raw);

    `SOS_NEVER(a_push_only_empty, clk, rst_n, cmd_push && (cmd_count != 2'd0), "push while busy")
    `SOS_NEVER(a_pop_only_nonempty, clk, rst_n, cmd_pop && (cmd_count == 2'd0), "pop while empty")
    `SOS_ASSERT(a_pop_drains, clk, rst_n, cmd_pop |=> (cmd_count == 2'd0), "pop left entries")

endmodule

`default_nettype wire
